>>> sv/brdp_pkg.sv
// Shared types and codes for the base relocation directory parser.
// No dependencies; used by brdp_core and base_relocation_directory_parser_top.
package brdp_pkg;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int TYPE_W   = 4;
    localparam int OFFSET_W = 12;
    localparam int CFG_IDX_W = 2;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [ERR_W-1:0]     t_err;
    typedef logic [TYPE_W-1:0]    t_type;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_kind KIND_TARGET = 2'd0;
    localparam t_kind KIND_ERROR  = 2'd1;
    localparam t_kind KIND_END    = 2'd2;

    localparam t_err ERR_DIR_OUTSIDE = 3'd0;
    localparam t_err ERR_MALFORMED   = 3'd1;
    localparam t_err ERR_MISALIGNED  = 3'd2;
    localparam t_err ERR_BAD_TYPE    = 3'd3;
    localparam t_err ERR_OVERFLOW    = 3'd4;
    localparam t_err ERR_TGT_OUTSIDE = 3'd5;
    localparam t_err ERR_NONE        = 3'd0;

    localparam t_type TYPE_ABSOLUTE = 4'd0;
    localparam t_type TYPE_HIGHLOW  = 4'd3;
    localparam t_type TYPE_DIR64    = 4'd10;

    localparam t_cfg_idx CFG_DIR_START  = 2'd0;
    localparam t_cfg_idx CFG_DIR_LENGTH = 2'd1;
    localparam t_cfg_idx CFG_IMG_LENGTH = 2'd2;
    localparam t_cfg_idx CFG_WIDE_PTRS  = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] dir_start;
        logic [ADDR_W-1:0] dir_length;
        logic [ADDR_W-1:0] img_length;
        logic              wide_ptrs;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [ADDR_W-1:0] target;
        t_err              code;
        logic              final_res;
    } t_result;

endpackage

>>> sv/base_relocation_directory_parser_top.sv
// Base relocation directory parser: one directory byte per beat in, at most one result out.
// A byte is accepted every cycle while results are taken; each byte passes an input
// register, a combinational decode in brdp_core, and a result register. Only a byte
// that produces a result waits for a free result register. Configuration writes are
// registered; ready is always high.
// Depends on brdp_pkg and brdp_core.
module base_relocation_directory_parser_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_restart,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_kind,
    output logic [31:0]              o_target_address,
    output logic [2:0]               o_fault_code,
    output logic                     o_final_res,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  brdp_pkg::t_cfg_idx       i_cfg_index,
    input  logic [31:0]              i_cfg_data
);
    import brdp_pkg::*;

    t_cfg        r_cfg;
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_restart;
    t_result     r_out;
    t_result     res;
    logic        out_free;
    logic        s1_go;
    logic        in_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dir_start: '0, dir_length: '0, img_length: '0, wide_ptrs: 1'b1};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIR_START:  r_cfg.dir_start  <= i_cfg_data;
                CFG_DIR_LENGTH: r_cfg.dir_length <= i_cfg_data;
                CFG_IMG_LENGTH: r_cfg.img_length <= i_cfg_data;
                CFG_WIDE_PTRS:  r_cfg.wide_ptrs  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    brdp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (s1_go),
        .i_byte    (r_s1_byte),
        .i_restart (r_s1_restart),
        .i_cfg     (r_cfg),
        .o_res     (res)
    );

    assign out_free   = !r_out.valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!res.valid || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_byte    <= i_data_byte;
            r_s1_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (s1_go && res.valid) begin
            r_out <= res;
        end else if (!i_out_stall) begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out.valid;
    assign o_kind           = r_out.kind;
    assign o_target_address = r_out.target;
    assign o_fault_code     = r_out.code;
    assign o_final_res      = r_out.final_res;

endmodule

>>> sv/brdp_core.sv
// Parser state and per-byte decode of the relocation directory.
// Depends on brdp_pkg; the result is combinational from state and the current byte.
module brdp_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_byte,
    input  logic                    i_restart,
    input  brdp_pkg::t_cfg          i_cfg,
    output brdp_pkg::t_result       o_res
);
    import brdp_pkg::*;

    logic [ADDR_W-1:0] r_pos,  n_pos,  c_pos;
    logic              r_inh,  n_inh,  c_inh;
    logic [55:0]       r_hdr,  n_hdr;
    logic [2:0]        r_cnt,  n_cnt,  c_cnt;
    logic [ADDR_W-1:0] r_blk,  n_blk,  c_blk;
    logic [8:0]        r_low,  n_low,  c_low;
    logic              r_stop, n_stop, c_stop;
    logic [ADDR_W-1:0] r_page, n_page, c_page;

    logic              pos0;
    logic              last;
    logic [ADDR_W:0]   dir_end;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] remaining;
    logic [ADDR_W-1:0] blk_dec;
    t_type             etype;
    t_type             expected;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W:0]   tgt;
    logic [ADDR_W+1:0] tgt_end;
    logic [ADDR_W+1:0] width;
    t_result           res;

    assign c_pos  = i_restart ? '0   : r_pos;
    assign c_inh  = i_restart ? 1'b1 : r_inh;
    assign c_cnt  = i_restart ? '0   : r_cnt;
    assign c_blk  = i_restart ? '0   : r_blk;
    assign c_low  = i_restart ? '0   : r_low;
    assign c_stop = i_restart ? 1'b0 : r_stop;
    assign c_page = i_restart ? '0   : r_page;

    assign pos0      = (c_pos == '0);
    assign last      = (({1'b0, c_pos} + 33'd1) == {1'b0, i_cfg.dir_length});
    assign dir_end   = {1'b0, i_cfg.dir_start} + {1'b0, i_cfg.dir_length};
    assign size      = {i_byte, r_hdr[55:32]};
    assign remaining = i_cfg.dir_length - (c_pos - 32'd7);
    assign blk_dec   = (c_blk != '0) ? c_blk - 32'd1 : '0;
    assign etype     = i_byte[7:4];
    assign expected  = i_cfg.wide_ptrs ? TYPE_DIR64 : TYPE_HIGHLOW;
    assign offset    = {i_byte[3:0], c_low[7:0]};
    assign width     = i_cfg.wide_ptrs ? 34'd8 : 34'd4;
    assign tgt       = {1'b0, c_page} + {{(ADDR_W+1-OFFSET_W){1'b0}}, offset};
    assign tgt_end   = {1'b0, tgt} + width;

    always_comb begin
        n_pos  = c_pos;
        n_inh  = c_inh;
        n_hdr  = r_hdr;
        n_cnt  = c_cnt;
        n_blk  = c_blk;
        n_low  = c_low;
        n_stop = c_stop;
        n_page = c_page;
        res    = '0;
        if (!c_stop) begin
            if (pos0 && (i_cfg.dir_start == '0 || i_cfg.dir_length == '0)) begin
                res = '{1'b1, KIND_END, '0, ERR_NONE, 1'b1};
            end else if (pos0 && (dir_end > {1'b0, i_cfg.img_length})) begin
                res = '{1'b1, KIND_ERROR, '0, ERR_DIR_OUTSIDE, 1'b1};
            end else if (!pos0 && (c_pos >= i_cfg.dir_length)) begin
                res = '{1'b1, KIND_END, '0, ERR_NONE, 1'b1};
            end else begin
                n_pos = c_pos + 32'd1;
                if (c_inh) begin
                    if (c_cnt != 3'd7) begin
                        n_hdr[{c_cnt, 3'b000} +: 8] = i_byte;
                        n_cnt = c_cnt + 3'd1;
                        if (last) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_MALFORMED, 1'b1};
                        end
                    end else begin
                        n_cnt  = '0;
                        n_page = r_hdr[31:0];
                        if (size < 32'd8 || size > remaining) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_MALFORMED, 1'b1};
                        end else if (size[0]) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_MISALIGNED, 1'b1};
                        end else begin
                            n_blk = size - 32'd8;
                            n_low = '0;
                            if (size != 32'd8) begin
                                n_inh = 1'b0;
                            end
                            if (last) begin
                                res = '{1'b1, KIND_END, '0, ERR_NONE, 1'b1};
                            end
                        end
                    end
                end else begin
                    n_blk = blk_dec;
                    if (blk_dec == '0) begin
                        n_inh = 1'b1;
                        n_cnt = '0;
                    end
                    if (!c_low[8]) begin
                        n_low = {1'b1, i_byte};
                        if (last) begin
                            res = '{1'b1, KIND_END, '0, ERR_NONE, 1'b1};
                        end
                    end else begin
                        n_low = '0;
                        if (etype == TYPE_ABSOLUTE) begin
                            if (last) begin
                                res = '{1'b1, KIND_END, '0, ERR_NONE, 1'b1};
                            end
                        end else if (etype != expected) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_BAD_TYPE, 1'b1};
                        end else if (tgt[ADDR_W]) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_OVERFLOW, 1'b1};
                        end else if (tgt_end > {2'b00, i_cfg.img_length}) begin
                            res = '{1'b1, KIND_ERROR, '0, ERR_TGT_OUTSIDE, 1'b1};
                        end else begin
                            res = '{1'b1, KIND_TARGET, tgt[ADDR_W-1:0], ERR_NONE, last};
                        end
                    end
                end
            end
            if (res.valid && res.final_res) begin
                n_stop = 1'b1;
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_inh  <= 1'b1;
            r_cnt  <= '0;
            r_blk  <= '0;
            r_low  <= '0;
            r_stop <= 1'b0;
            r_page <= '0;
            r_hdr  <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_inh  <= n_inh;
            r_cnt  <= n_cnt;
            r_blk  <= n_blk;
            r_low  <= n_low;
            r_stop <= n_stop;
            r_page <= n_page;
            r_hdr  <= n_hdr;
        end
    end

endmodule
